### rtl/core/bmrsct_pkg.sv
// Shared types, codes and constants of the bitmap range set/clear/test block.
`default_nettype none

package bmrsct_pkg;

	// Default size of the bitmap in bytes.
	localparam int BITMAP_BYTES_DEF = 512;

	// Request field widths.
	localparam int CMD_W      = 2;
	localparam int START_W    = 12;
	localparam int COUNT_W    = 13;
	// Width of start plus count, which reaches at most 4095 + 8191 = 12286.
	localparam int END_W      = 14;
	// Byte index width; the largest reachable byte follows from END_W.
	localparam int BYTE_IDX_W = END_W - 3;
	localparam int BYTE_W     = 8;

	// Byte mask of all ones.
	localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
	// Highest bit position inside a byte.
	localparam logic [2:0] BIT_POS_MAX = 3'd7;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Command codes on the request port.
	typedef enum logic [CMD_W-1:0] {
		CMD_SET   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_TEST  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// Work kinds handed from front to back.
	typedef enum logic [1:0] {
		OP_SET    = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_TEST   = 2'd2,
		OP_REPORT = 2'd3
	} op_t;

	// Classified request carried through the queue.
	typedef struct packed {
		op_t                   op;
		logic [BYTE_IDX_W-1:0] first_byte;
		logic [BYTE_IDX_W-1:0] last_byte;
		logic [BYTE_W-1:0]     first_mask;
		logic [BYTE_W-1:0]     last_mask;
		logic                  all_set;
		logic                  range_error;
	} req_t;

	// Result strobe and fields from the back end.
	typedef struct packed {
		logic done;
		logic all_set;
		logic range_error;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/bmrsct_front.sv
// Front end: accepts requests and splits each range into byte bounds and masks.
`default_nettype none

module bmrsct_front #(
	parameter int BITMAP_BYTES = bmrsct_pkg::BITMAP_BYTES_DEF
) (
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [bmrsct_pkg::CMD_W-1:0]      command,
	input  wire logic [bmrsct_pkg::START_W-1:0]    start_bit,
	input  wire logic [bmrsct_pkg::COUNT_W-1:0]    bit_count,
	input  wire logic                              queue_full,
	input  wire logic                              init_busy,
	output logic                                   push,
	output bmrsct_pkg::req_t                       req
);

	localparam int TOTAL_BITS = BITMAP_BYTES * 8;
	localparam int TOTAL_W    = $clog2(TOTAL_BITS + 1);
	localparam int CMP_W      = (TOTAL_W > bmrsct_pkg::END_W) ? TOTAL_W : bmrsct_pkg::END_W;

	logic [bmrsct_pkg::END_W-1:0] end_bit;
	logic [bmrsct_pkg::END_W-1:0] last_bit;
	logic                         over_end;
	logic                         zero_count;
	bmrsct_pkg::cmd_t             cmd;

	// Requests are taken whenever the queue has room and the clearing pass is over.
	assign busy = queue_full | init_busy;
	assign push = start & ~busy;

	// Range end and the check against the bitmap size.
	assign cmd        = bmrsct_pkg::cmd_t'(command);
	assign end_bit    = bmrsct_pkg::END_W'(start_bit) + bmrsct_pkg::END_W'(bit_count);
	assign last_bit   = end_bit - bmrsct_pkg::END_W'(1);
	assign over_end   = CMP_W'(end_bit) > CMP_W'(TOTAL_BITS);
	assign zero_count = bit_count == '0;

	// Classify the request and derive the masks of the first and last bytes.
	always_comb begin
		req.first_byte  = bmrsct_pkg::BYTE_IDX_W'(start_bit[bmrsct_pkg::START_W-1:3]);
		req.last_byte   = last_bit[bmrsct_pkg::BYTE_IDX_W+2:3];
		req.first_mask  = bmrsct_pkg::BYTE_ONES >> start_bit[2:0];
		req.last_mask   = bmrsct_pkg::BYTE_ONES << (bmrsct_pkg::BIT_POS_MAX - last_bit[2:0]);
		req.range_error = over_end;
		req.all_set     = 1'b0;
		req.op          = bmrsct_pkg::OP_REPORT;
		if (!over_end && zero_count) begin
			req.all_set = cmd == bmrsct_pkg::CMD_TEST;
		end else if (!over_end) begin
			case (cmd)
				bmrsct_pkg::CMD_SET: begin
					req.op = bmrsct_pkg::OP_SET;
				end
				bmrsct_pkg::CMD_CLEAR: begin
					req.op = bmrsct_pkg::OP_CLEAR;
				end
				bmrsct_pkg::CMD_TEST: begin
					req.op = bmrsct_pkg::OP_TEST;
				end
				default: begin
					req.op = bmrsct_pkg::OP_REPORT;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/bmrsct_queue.sv
// Short first-in first-out queue of classified requests between front and back.
`default_nettype none

module bmrsct_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire bmrsct_pkg::req_t push_req,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output bmrsct_pkg::req_t      head
);

	localparam int DEPTH = bmrsct_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bmrsct_pkg::req_t   entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign valid = count_q != '0;
	assign head  = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_req;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/bmrsct_back.sv
// Back end: owns the bitmap memory and walks each range one byte at a time.
`default_nettype none

module bmrsct_back #(
	parameter int BITMAP_BYTES = bmrsct_pkg::BITMAP_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire bmrsct_pkg::req_t req,
	output logic                  pop,
	output logic                  init_busy,
	output bmrsct_pkg::result_t   result
);

	localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;

	typedef enum logic [3:0] {
		ST_INIT  = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_CHECK = 4'b1000
	} state_t;

	state_t                                state_q;
	logic [AW-1:0]                         init_q;
	bmrsct_pkg::req_t                      item_q;
	logic [bmrsct_pkg::BYTE_IDX_W-1:0]     cur_q;
	logic [bmrsct_pkg::BYTE_W-1:0]         rdata_q;
	bmrsct_pkg::result_t                   result_q;
	logic [bmrsct_pkg::BYTE_W-1:0]         mem_q [BITMAP_BYTES];

	logic [bmrsct_pkg::BYTE_W-1:0]         mask;
	logic                                  at_last;
	logic                                  test_fail;
	logic                                  wr_en;
	logic [AW-1:0]                         wr_addr;
	logic [bmrsct_pkg::BYTE_W-1:0]         wr_data;

	assign init_busy = state_q == ST_INIT;
	assign pop       = (state_q == ST_IDLE) && req_valid;
	assign result    = result_q;

	// Mask of the range bits in the current byte.
	always_comb begin
		mask = bmrsct_pkg::BYTE_ONES;
		if (cur_q == item_q.first_byte) begin
			mask = mask & item_q.first_mask;
		end
		if (cur_q == item_q.last_byte) begin
			mask = mask & item_q.last_mask;
		end
	end

	assign at_last   = cur_q == item_q.last_byte;
	assign test_fail = (rdata_q & mask) != mask;

	// Memory write port: clearing pass after reset, or the update of one byte.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(cur_q);
		wr_data = rdata_q | mask;
		if (state_q == ST_INIT) begin
			wr_en   = 1'b1;
			wr_addr = init_q;
			wr_data = '0;
		end else if (state_q == ST_CHECK) begin
			if (item_q.op == bmrsct_pkg::OP_SET) begin
				wr_en = 1'b1;
			end else if (item_q.op == bmrsct_pkg::OP_CLEAR) begin
				wr_en   = 1'b1;
				wr_data = rdata_q & ~mask;
			end
		end
	end

	// Bitmap memory with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (state_q == ST_READ) begin
			rdata_q <= mem_q[AW'(cur_q)];
		end
	end

	// Held request and byte cursor.
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= req;
			cur_q  <= req.first_byte;
		end else if (state_q == ST_CHECK) begin
			cur_q <= cur_q + bmrsct_pkg::BYTE_IDX_W'(1);
		end
	end

	// Sequencer and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			init_q   <= '0;
			result_q <= '0;
		end else begin
			result_q.done <= 1'b0;
			case (state_q)
				ST_INIT: begin
					init_q <= init_q + AW'(1);
					if (init_q == AW'(BITMAP_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						if (req.op == bmrsct_pkg::OP_REPORT) begin
							result_q.done        <= 1'b1;
							result_q.all_set     <= req.all_set;
							result_q.range_error <= req.range_error;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (item_q.op == bmrsct_pkg::OP_TEST && test_fail) begin
						result_q.done        <= 1'b1;
						result_q.all_set     <= 1'b0;
						result_q.range_error <= 1'b0;
						state_q              <= ST_IDLE;
					end else if (at_last) begin
						result_q.done        <= 1'b1;
						result_q.all_set     <= item_q.op == bmrsct_pkg::OP_TEST;
						result_q.range_error <= 1'b0;
						state_q              <= ST_IDLE;
					end else begin
						state_q <= ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/bitmap_range_set_clear_test_core.sv
// Top level of the bitmap range set/clear/test block.
//
// A request (command, start_bit, bit_count) is taken at a rising edge where
// start is high and busy is low. Commands set, clear or test a range of bits
// in a BITMAP_BYTES-byte bitmap, numbered from the top bit of byte 0 down.
// Each request yields one result: done is high for exactly one cycle with
// all_set and range_error valid in that cycle. The receiver cannot stall.
//
// The front end classifies each request and drops it into a two-entry queue;
// the back end walks the range with read-modify-write on a single-port byte
// memory, through a READ and a CHECK state for each byte touched. A range
// error, a zero count or the unused command is reported from the idle state
// with no memory access. A test stops at the first byte with a clear bit.
// The back end takes one request at a time; the front end keeps taking
// requests while the queue has room.
// After reset the bitmap is swept to zeros, one byte per cycle;
// busy stays high until the sweep is done.
`default_nettype none

module bitmap_range_set_clear_test_core #(
	parameter int BITMAP_BYTES = bmrsct_pkg::BITMAP_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [bmrsct_pkg::CMD_W-1:0]   command,
	input  wire logic [bmrsct_pkg::START_W-1:0] start_bit,
	input  wire logic [bmrsct_pkg::COUNT_W-1:0] bit_count,
	output logic                                done,
	output logic                                all_set,
	output logic                                range_error
);

	logic                queue_full;
	logic                init_busy;
	logic                push;
	bmrsct_pkg::req_t    push_req;
	logic                pop;
	logic                head_valid;
	bmrsct_pkg::req_t    head_req;
	bmrsct_pkg::result_t result;

	// Request intake and classification.
	bmrsct_front #(
		.BITMAP_BYTES(BITMAP_BYTES)
	) u_front (
		.start      (start),
		.busy       (busy),
		.command    (command),
		.start_bit  (start_bit),
		.bit_count  (bit_count),
		.queue_full (queue_full),
		.init_busy  (init_busy),
		.push       (push),
		.req        (push_req)
	);

	// Queue between front and back.
	bmrsct_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.full     (queue_full),
		.pop      (pop),
		.valid    (head_valid),
		.head     (head_req)
	);

	// Range walk over the bitmap memory.
	bmrsct_back #(
		.BITMAP_BYTES(BITMAP_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (head_valid),
		.req       (head_req),
		.pop       (pop),
		.init_busy (init_busy),
		.result    (result)
	);

	assign done        = result.done;
	assign all_set     = result.all_set;
	assign range_error = result.range_error;

endmodule

`default_nettype wire
